// ===== rtl/core/frnl_pkg.sv =====
package frnl_pkg;

   localparam int MAX_SLOTS_DEF  = 32;
   localparam int COORD_BITS_DEF = 24;

   localparam int RANGE_W = 23;
   localparam int LIMIT_W = 6;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(10);

   localparam int INDEX_W = 5;
   localparam int MASK_W  = 32;
   localparam int COUNT_W = 6;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_LINK_RANGE     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_NEIGHBOR_LIMIT = CSR_IDX_W'(1);

   localparam int PROD_W = 2 * RANGE_W;
   localparam int ACC_W  = PROD_W + 2;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   typedef enum logic [6:0] {
      S_LOAD = 7'b0000001,
      S_RDI  = 7'b0000010,
      S_LATI = 7'b0000100,
      S_SCAN = 7'b0001000,
      S_AXIS = 7'b0010000,
      S_SQ   = 7'b0100000,
      S_DEC  = 7'b1000000
   } state_type;

endpackage

// ===== rtl/core/frnl_if.sv =====
interface frnl_req_if #(
   parameter int COORD_BITS = frnl_pkg::COORD_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] pos_x;
   logic [COORD_BITS-1:0] pos_y;
   logic [COORD_BITS-1:0] pos_z;
   logic                  active;
   logic                  last;

   modport source (output valid, pos_x, pos_y, pos_z, active, last, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, active, last, output ready);
endinterface

interface frnl_rsp_if;
   import frnl_pkg::*;
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] point_index;
   logic [MASK_W-1:0]  neighbor_mask;
   logic [COUNT_W-1:0] kept_count;
   logic               overflowed;
   logic               final_res;

   modport source (output valid, point_index, neighbor_mask, kept_count,
                   overflowed, final_res, input ready);
   modport sink   (input valid, point_index, neighbor_mask, kept_count,
                   overflowed, final_res, output ready);
endinterface

interface frnl_csr_if;
   import frnl_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/frnl_point_mem.sv =====
module frnl_point_mem #(
   parameter int DEPTH = frnl_pkg::MAX_SLOTS_DEF,
   parameter int WIDTH = 3 * frnl_pkg::COORD_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/core/fixed_radius_neighbor_lists_unit.sv =====
// Fixed-radius neighbor lists.
// req_ch: one point per beat (x, y, z in signed fixed point, active, last).
//   Beats are taken while loading. A beat with last closes the set.
// rsp_ch: after a set closes, one beat per loaded point in index order, with
//   the mask and count of its kept neighbors; final_res marks the last one.
// csr_ch: register writes (0 link_range, 1 neighbor_limit), always ready; the
//   user must write them only while the block is loading and no set is being
//   processed, as the block itself does not enforce it.
// Per point: fetch it and compute range squared, then for each other slot
//   either skip it (self, inactive) or test it: fetch it, then per axis the
//   diff, then square and accumulate on the one shared multiplier, then a
//   decision. An axis over range ends the test early, and the scan stops once
//   the limit is reached. Then the scan closes and the result beat is offered.
// req_ch is not ready while a set is processed. A stalled rsp_ch holds the
//   result beat and the sequencer waits on it.
// Reset clears the set, the flags and the registers (link_range 0, limit 10).
module fixed_radius_neighbor_lists_unit #(
   parameter int MAX_SLOTS  = frnl_pkg::MAX_SLOTS_DEF,
   parameter int COORD_BITS = frnl_pkg::COORD_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   frnl_req_if.sink   req_ch,
   frnl_rsp_if.source rsp_ch,
   frnl_csr_if.sink   csr_ch
);
   import frnl_pkg::*;

   localparam int IDX_W  = $clog2(MAX_SLOTS);
   localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
   localparam int CMP_W  = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
   localparam int WORD_W = 3 * COORD_BITS;
   localparam int DIFF_W = COORD_BITS + 1;
   localparam int DW     = (DIFF_W > RANGE_W) ? DIFF_W : RANGE_W;

   state_type state_ff, state_in;

   logic [RANGE_W-1:0]   range_ff, range_in;
   logic [LIMIT_W-1:0]   limit_ff, limit_in;
   logic [MAX_SLOTS-1:0] active_ff, active_in;
   logic [CNT_W-1:0]     loaded_ff, loaded_in;
   logic                 ovf_ff, ovf_in;

   logic [IDX_W-1:0]     i_ff, i_in;
   logic [CNT_W-1:0]     j_ff, j_in;
   axis_type             axis_ff, axis_in;
   logic [MAX_SLOTS-1:0] mask_ff, mask_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 out_ff, out_in;

   logic [WORD_W-1:0]  ci_ff, ci_in;
   logic [RANGE_W-1:0] d_ff, d_in;
   logic [PROD_W-1:0]  rr_ff, rr_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;

   logic               mem_wr_en;
   logic [IDX_W-1:0]   mem_wr_addr;
   logic [WORD_W-1:0]  mem_wr_data;
   logic               mem_rd_en;
   logic [IDX_W-1:0]   mem_rd_addr;
   logic [WORD_W-1:0]  mem_rd_data;

   logic [RANGE_W-1:0]    mul_a;
   logic [PROD_W-1:0]     prod;
   logic [COORD_BITS-1:0] ca, cb;
   logic [DIFF_W-1:0]     diff, absd;
   logic                  too_far;
   logic                  req_acc, rsp_acc, is_final, limit_hit, skip_j;
   logic [IDX_W-1:0]      j_idx;

   frnl_point_mem #(.DEPTH(MAX_SLOTS), .WIDTH(WORD_W)) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign req_ch.ready = (state_ff == S_LOAD) && !out_ff;
   assign csr_ch.ready = 1'b1;
   assign req_acc = req_ch.valid && req_ch.ready;
   assign rsp_acc = rsp_ch.valid && rsp_ch.ready;

   assign rsp_ch.valid         = out_ff;
   assign rsp_ch.point_index   = INDEX_W'(i_ff);
   assign rsp_ch.neighbor_mask = MASK_W'(mask_ff);
   assign rsp_ch.kept_count    = COUNT_W'(count_ff);
   assign rsp_ch.overflowed    = ovf_ff;
   assign rsp_ch.final_res     = is_final;

   assign is_final  = (CNT_W'(i_ff) + CNT_W'(1)) == loaded_ff;
   assign j_idx     = j_ff[IDX_W-1:0];
   assign limit_hit = CMP_W'(count_ff) >= CMP_W'(limit_ff);
   assign skip_j    = (j_idx == i_ff) || !active_ff[j_idx];

   // shared multiplier: range squared at point fetch, axis squares otherwise
   assign mul_a = (state_ff == S_RDI) ? range_ff : d_ff;
   assign prod  = PROD_W'(mul_a) * PROD_W'(mul_a);

   always_comb begin
      case (axis_ff)
         AXIS_X: begin
            ca = ci_ff[WORD_W-1 -: COORD_BITS];
            cb = mem_rd_data[WORD_W-1 -: COORD_BITS];
         end
         AXIS_Y: begin
            ca = ci_ff[2*COORD_BITS-1 -: COORD_BITS];
            cb = mem_rd_data[2*COORD_BITS-1 -: COORD_BITS];
         end
         default: begin
            ca = ci_ff[COORD_BITS-1:0];
            cb = mem_rd_data[COORD_BITS-1:0];
         end
      endcase
      diff    = {ca[COORD_BITS-1], ca} - {cb[COORD_BITS-1], cb};
      absd    = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
      too_far = DW'(absd) > DW'(range_ff);
   end

   always_comb begin
      state_in  = state_ff;
      range_in  = range_ff;
      limit_in  = limit_ff;
      active_in = active_ff;
      loaded_in = loaded_ff;
      ovf_in    = ovf_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      axis_in   = axis_ff;
      mask_in   = mask_ff;
      count_in  = count_ff;
      out_in    = out_ff;
      ci_in     = ci_ff;
      d_in      = d_ff;
      rr_in     = rr_ff;
      acc_in    = acc_ff;

      mem_wr_en   = 1'b0;
      mem_wr_addr = loaded_ff[IDX_W-1:0];
      mem_wr_data = {req_ch.pos_x, req_ch.pos_y, req_ch.pos_z};
      mem_rd_en   = 1'b0;
      mem_rd_addr = j_idx;

      if (csr_ch.valid && csr_ch.ready) begin
         if (csr_ch.index == CSR_LINK_RANGE) begin
            range_in = csr_ch.data[RANGE_W-1:0];
         end else if (csr_ch.index == CSR_NEIGHBOR_LIMIT) begin
            limit_in = csr_ch.data[LIMIT_W-1:0];
         end
      end

      case (state_ff)
         S_LOAD: begin
            if (out_ff) begin
               if (rsp_acc) begin
                  out_in = 1'b0;
                  if (is_final) begin
                     active_in = '0;
                     loaded_in = '0;
                     ovf_in    = 1'b0;
                  end else begin
                     i_in     = i_ff + IDX_W'(1);
                     state_in = S_RDI;
                  end
               end
            end else if (req_acc) begin
               if (loaded_ff < CNT_W'(MAX_SLOTS)) begin
                  mem_wr_en = 1'b1;
                  active_in[loaded_ff[IDX_W-1:0]] = req_ch.active;
                  loaded_in = loaded_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_ch.last) begin
                  i_in     = '0;
                  state_in = S_RDI;
               end
            end
         end
         S_RDI: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = i_ff;
            rr_in       = prod;
            state_in    = S_LATI;
         end
         S_LATI: begin
            ci_in    = mem_rd_data;
            j_in     = '0;
            mask_in  = '0;
            count_in = '0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if ((j_ff == loaded_ff) || limit_hit) begin
               out_in   = 1'b1;
               state_in = S_LOAD;
            end else if (skip_j) begin
               j_in = j_ff + CNT_W'(1);
            end else begin
               mem_rd_en = 1'b1;
               acc_in    = '0;
               axis_in   = AXIS_X;
               state_in  = S_AXIS;
            end
         end
         S_AXIS: begin
            if (too_far) begin
               j_in     = j_ff + CNT_W'(1);
               state_in = S_SCAN;
            end else begin
               d_in     = absd[RANGE_W-1:0];
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            acc_in = acc_ff + ACC_W'(prod);
            if (axis_ff == AXIS_Z) begin
               state_in = S_DEC;
            end else begin
               axis_in  = (axis_ff == AXIS_X) ? AXIS_Y : AXIS_Z;
               state_in = S_AXIS;
            end
         end
         S_DEC: begin
            if (acc_ff <= ACC_W'(rr_ff)) begin
               mask_in[j_idx] = 1'b1;
               count_in       = count_ff + CNT_W'(1);
            end
            j_in     = j_ff + CNT_W'(1);
            state_in = S_SCAN;
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_LOAD;
         range_ff  <= '0;
         limit_ff  <= LIMIT_RESET;
         active_ff <= '0;
         loaded_ff <= '0;
         ovf_ff    <= 1'b0;
         out_ff    <= 1'b0;
         i_ff      <= '0;
         j_ff      <= '0;
         axis_ff   <= AXIS_X;
         count_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         range_ff  <= range_in;
         limit_ff  <= limit_in;
         active_ff <= active_in;
         loaded_ff <= loaded_in;
         ovf_ff    <= ovf_in;
         out_ff    <= out_in;
         i_ff      <= i_in;
         j_ff      <= j_in;
         axis_ff   <= axis_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff <= mask_in;
      ci_ff   <= ci_in;
      d_ff    <= d_in;
      rr_ff   <= rr_in;
      acc_ff  <= acc_in;
   end
endmodule
